FILE: rtl/gbnd_pkg.sv
// ----------------------------------------------------------------------------
// gbnd_pkg
// Shared types, register indexes and the GCR 5-to-4 lookup for the decoder.
// ----------------------------------------------------------------------------
package gbnd_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_BIT  = 1'b1;

  // One raw item on its way into the decoder
  typedef struct packed {
    logic [7:0] raw_byte;
    logic       final_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       bad_code;
    logic       end_mark;
  } result_t;

  // Bit 4: code valid, bits 3..0: nibble (zero for an invalid code)
  localparam logic [4:0] GCR_TABLE [32] = '{
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
    5'h00, 5'h18, 5'h10, 5'h11, 5'h00, 5'h1C, 5'h14, 5'h15,
    5'h00, 5'h00, 5'h12, 5'h13, 5'h00, 5'h1F, 5'h16, 5'h17,
    5'h00, 5'h19, 5'h1A, 5'h1B, 5'h00, 5'h1D, 5'h1E, 5'h00
  };

  function automatic logic [4:0] gcr_lookup(input logic [4:0] code);
    gcr_lookup = GCR_TABLE[code];
  endfunction

endpackage

FILE: rtl/gbnd_in_stage.sv
// ----------------------------------------------------------------------------
// gbnd_in_stage
// Input register: holds one raw item until the decode stage takes it.
// ----------------------------------------------------------------------------
module gbnd_in_stage import gbnd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/gbnd_core.sv
// ----------------------------------------------------------------------------
// gbnd_core
// Stream state, GCR group extraction and nibble packing for one item.
// ----------------------------------------------------------------------------
module gbnd_core import gbnd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  item_t                 item,
  input  logic                  space,
  output logic                  item_take,
  output logic                  res_load,
  output result_t               res
);

  // configuration
  logic [15:0] skip_bytes_r;
  logic [2:0]  start_bit_r;

  // stream state; at most four ungrouped bits remain between items
  logic [3:0]  bit_store_r, bit_store_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [3:0]  held_nib_r, held_nib_nxt;
  logic        nib_held_r, nib_held_nxt;
  logic        held_bad_r, held_bad_nxt;
  logic [15:0] skip_left_r, skip_left_nxt;
  logic        first_pend_r, first_pend_nxt;

  logic [2:0]  sb;
  logic [3:0]  nb;
  logic [7:0]  bits;
  logic [11:0] comb_bits;
  logic [3:0]  cnt, sh1, sh2, rem;
  logic        g1, g2;
  logic [4:0]  ent1, ent2;
  logic        got;
  logic [7:0]  byte_val;
  logic        byte_bad;

  assign item_take = item_valid && space;

  // merge the new bits behind the leftover ones
  always_comb begin
    sb        = first_pend_r ? start_bit_r : 3'd0;
    nb        = 4'd8 - {1'b0, sb};
    bits      = item.raw_byte & (8'hff >> sb);
    comb_bits = ({8'd0, bit_store_r} << nb) | {4'd0, bits};
    cnt       = bit_count_r + nb;
    g1        = cnt >= 4'd5;
    g2        = cnt >= 4'd10;
    sh1       = cnt - 4'd5;
    sh2       = cnt - 4'd10;
    ent1      = gcr_lookup(5'(comb_bits >> sh1));
    ent2      = gcr_lookup(5'(comb_bits >> sh2));
    rem       = g2 ? sh2 : (g1 ? sh1 : cnt);
  end

  // state update and result for the item in hand
  always_comb begin
    bit_store_nxt  = bit_store_r;
    bit_count_nxt  = bit_count_r;
    held_nib_nxt   = held_nib_r;
    nib_held_nxt   = nib_held_r;
    held_bad_nxt   = held_bad_r;
    skip_left_nxt  = skip_left_r;
    first_pend_nxt = first_pend_r;
    got            = 1'b0;
    byte_val       = 8'd0;
    byte_bad       = 1'b0;

    if (skip_left_r != 16'd0) begin
      skip_left_nxt = skip_left_r - 16'd1;
    end else begin
      first_pend_nxt = 1'b0;
      bit_count_nxt  = rem;
      bit_store_nxt  = 4'(comb_bits & ((12'd1 << rem) - 12'd1));
      if (g2) begin
        got = 1'b1;
        if (nib_held_r) begin
          // held nibble pairs with the first group, second is held
          byte_val     = {held_nib_r, ent1[3:0]};
          byte_bad     = held_bad_r | !ent1[4];
          held_nib_nxt = ent2[3:0];
          held_bad_nxt = !ent2[4];
          nib_held_nxt = 1'b1;
        end else begin
          byte_val     = {ent1[3:0], ent2[3:0]};
          byte_bad     = !ent1[4] | !ent2[4];
          held_nib_nxt = 4'd0;
          held_bad_nxt = 1'b0;
          nib_held_nxt = 1'b0;
        end
      end else if (g1) begin
        if (nib_held_r) begin
          got          = 1'b1;
          byte_val     = {held_nib_r, ent1[3:0]};
          byte_bad     = held_bad_r | !ent1[4];
          held_nib_nxt = 4'd0;
          held_bad_nxt = 1'b0;
          nib_held_nxt = 1'b0;
        end else begin
          held_nib_nxt = ent1[3:0];
          held_bad_nxt = !ent1[4];
          nib_held_nxt = 1'b1;
        end
      end
    end

    // final item: drop leftovers and start a new stream
    if (item.final_byte) begin
      bit_store_nxt  = 4'd0;
      bit_count_nxt  = 4'd0;
      held_nib_nxt   = 4'd0;
      nib_held_nxt   = 1'b0;
      held_bad_nxt   = 1'b0;
      skip_left_nxt  = skip_bytes_r;
      first_pend_nxt = 1'b1;
    end
  end

  assign res_load      = item_take && (got || item.final_byte);
  assign res.data_byte = byte_val;
  assign res.has_byte  = got;
  assign res.bad_code  = byte_bad;
  assign res.end_mark  = item.final_byte;

  // registers; the user must write configuration only while idle (unenforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bytes_r <= 16'd0;
      start_bit_r  <= 3'd0;
      bit_store_r  <= 4'd0;
      bit_count_r  <= 4'd0;
      held_nib_r   <= 4'd0;
      nib_held_r   <= 1'b0;
      held_bad_r   <= 1'b0;
      skip_left_r  <= 16'd0;
      first_pend_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_BYTES: begin
          skip_bytes_r <= cfg_data;
          skip_left_r  <= cfg_data;
        end
        REG_START_BIT: begin
          start_bit_r <= cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end else if (item_take) begin
      bit_store_r  <= bit_store_nxt;
      bit_count_r  <= bit_count_nxt;
      held_nib_r   <= held_nib_nxt;
      nib_held_r   <= nib_held_nxt;
      held_bad_r   <= held_bad_nxt;
      skip_left_r  <= skip_left_nxt;
      first_pend_r <= first_pend_nxt;
    end
  end

endmodule

FILE: rtl/gbnd_out_stage.sv
// ----------------------------------------------------------------------------
// gbnd_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module gbnd_out_stage import gbnd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // room for a new result when empty or being drained now
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/gcr_bitstream_nibble_decoder.sv
// ----------------------------------------------------------------------------
// gcr_bitstream_nibble_decoder
// Commodore GCR 5-to-4 decoder for a raw byte stream, MSB first.
// ----------------------------------------------------------------------------
// One raw byte is taken every clock cycle while results are being drained.
// An item is registered on entry, then decoded by the GCR lookup and nibble
// packing logic, and its result (if any) is loaded into the output register
// when that register has room. A held result that is not taken keeps the
// item in the input register, so in_ready drops until out_ready returns.
// A byte gives a result only when it completes a decoded byte or carries
// final_byte; the final byte always gives one result with end_mark set and
// starts a new stream (skip count reloaded, start_bit applied again).
// Writing skip_bytes reloads the skip count at once. Write configuration
// only while no item is in flight.
// ----------------------------------------------------------------------------
module gcr_bitstream_nibble_decoder import gbnd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_raw_byte,
  input  logic                  in_final_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data_byte,
  output logic                  out_has_byte,
  output logic                  out_bad_code,
  output logic                  out_end_mark
);

  item_t   in_item, item;
  logic    item_valid, item_take, space, res_load;
  result_t res, out_res;

  assign in_item.raw_byte   = in_raw_byte;
  assign in_item.final_byte = in_final_byte;

  // input register
  gbnd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // decode and stream state
  gbnd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .space      (space),
    .item_take  (item_take),
    .res_load   (res_load),
    .res        (res)
  );

  // result register
  gbnd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_data_byte = out_res.data_byte;
  assign out_has_byte  = out_res.has_byte;
  assign out_bad_code  = out_res.bad_code;
  assign out_end_mark  = out_res.end_mark;

endmodule

FILE: tb/gcr_bitstream_nibble_decoder_test.sv
// ----------------------------------------------------------------------------
// gcr_bitstream_nibble_decoder_test
// Self-checking bench for the GCR 5-to-4 bit stream decoder. Raw bytes are
// built mostly from valid GCR groups, with invalid codes, skipped lead bytes,
// start bit offsets and loose noise mixed in. Every accepted item runs through
// a local model of the decoder and each result item is checked field by field,
// under several skip and start bit settings and with random idling on both
// channels.
// ----------------------------------------------------------------------------
module gcr_bitstream_nibble_decoder_test;
  import gbnd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_ITEMS    = 90;
  localparam int LONG_SKIP      = 260;

  // Commodore GCR code for each nibble value
  localparam logic [4:0] NIBBLE_CODE [16] = '{
    5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
    5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
  };

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_raw_byte   = 8'h00;
  logic                  in_final_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [7:0]            out_data_byte;
  logic                  out_has_byte;
  logic                  out_bad_code;
  logic                  out_end_mark;

  // Bench control
  item_t      raw_stream[$];
  result_t    decoded_bytes_due[$];
  idle_mode_e idle_mode    = IDLE_NONE;
  logic       in_taken     = 1'b0;
  logic       hold_req     = 1'b0;
  logic       hold_seen    = 1'b0;
  int         hold_left    = 0;
  int         quiet_cycles = 0;
  int         mismatches   = 0;
  int         next_skip    = 0;
  int         next_start   = 0;

  // Decoder model: configuration and stream state
  logic [15:0] skip_cfg;
  logic [2:0]  start_cfg;
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic [3:0]  pend_nibble;
  logic        pend_valid;
  logic        pend_bad;
  logic [15:0] skip_count;
  logic        at_stream_start;

  gcr_bitstream_nibble_decoder i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_byte   (in_raw_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_byte (out_data_byte),
    .out_has_byte  (out_has_byte),
    .out_bad_code  (out_bad_code),
    .out_end_mark  (out_end_mark)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // {valid, nibble}; an unknown code gives nibble 0 and valid low
  function automatic logic [4:0] decode_group(input logic [4:0] code);
    int n;
    decode_group = 5'h00;
    for (n = 0; n < 16; n++) begin
      if (NIBBLE_CODE[n] == code) decode_group = {1'b1, 4'(n)};
    end
  endfunction

  function automatic void restart_stream();
    acc_bits        = '0;
    acc_count       = '0;
    pend_nibble     = '0;
    pend_valid      = 1'b0;
    pend_bad        = 1'b0;
    skip_count      = skip_cfg;
    at_stream_start = 1'b1;
  endfunction

  function automatic void reset_model();
    skip_cfg  = '0;
    start_cfg = '0;
    restart_stream();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_SKIP_BYTES) begin
      skip_cfg   = value;
      skip_count = value;
    end else if (idx == REG_START_BIT) begin
      start_cfg = value[2:0];
    end
  endfunction

  // Feeds one raw byte; returns 1 when it gives a result item
  function automatic bit decode_raw_byte(input logic [7:0] raw, input logic fin,
                                         output result_t res);
    logic [3:0] width;
    logic [7:0] fresh_bits;
    logic [4:0] entry;
    logic       got;
    logic [7:0] byte_val;
    logic       byte_bad;
    got      = 1'b0;
    byte_val = 8'h00;
    byte_bad = 1'b0;
    if (skip_count != 0) begin
      skip_count = skip_count - 16'd1;
    end else begin
      width      = 4'd8;
      fresh_bits = raw;
      // leading bits of the first raw byte after the skip are dropped
      if (at_stream_start) begin
        width           = 4'd8 - start_cfg;
        fresh_bits      = raw & (8'hFF >> start_cfg);
        at_stream_start = 1'b0;
      end
      acc_bits  = (acc_bits << width) | 12'(fresh_bits);
      acc_count = acc_count + width;
      // cut off whole groups, oldest bits first
      while (acc_count >= 4'd5) begin
        acc_count = acc_count - 4'd5;
        entry     = decode_group(5'(acc_bits >> acc_count));
        acc_bits  = acc_bits & ((12'd1 << acc_count) - 12'd1);
        if (pend_valid) begin
          byte_val    = {pend_nibble, entry[3:0]};
          byte_bad    = pend_bad | ~entry[4];
          got         = 1'b1;
          pend_valid  = 1'b0;
          pend_nibble = '0;
          pend_bad    = 1'b0;
        end else begin
          pend_nibble = entry[3:0];
          pend_bad    = ~entry[4];
          pend_valid  = 1'b1;
        end
      end
    end
    res = '{data_byte: byte_val, has_byte: got, bad_code: byte_bad, end_mark: fin};
    if (fin) restart_stream();
    decode_raw_byte = got || fin;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_raw(input logic [7:0] raw, input logic fin);
    raw_stream.push_back('{raw_byte: raw, final_byte: fin});
  endfunction

  // One stream: lead bytes, start bit padding, groups, random tail bits.
  // Returns the number of bytes after the lead.
  task automatic gen_stream(input int lead, input int sb, input int groups,
                            input int bad_pct, output int body_bytes);
    bit         stream_bits[$];
    logic [4:0] code;
    logic [7:0] b;
    int         k;
    body_bytes = 0;
    repeat (lead) push_raw(8'($urandom), 1'b0);
    for (k = 0; k < sb; k++) stream_bits.push_back(1'($urandom));
    repeat (groups) begin
      if ($urandom_range(99) < bad_pct) code = 5'($urandom);
      else code = NIBBLE_CODE[$urandom_range(15)];
      for (k = 4; k >= 0; k--) stream_bits.push_back(code[k]);
    end
    while (stream_bits.size() == 0 || stream_bits.size() % 8 != 0)
      stream_bits.push_back(1'($urandom));
    while (stream_bits.size() != 0) begin
      for (k = 7; k >= 0; k--) b[k] = stream_bits.pop_front();
      push_raw(b, stream_bits.size() == 0);
      body_bytes++;
    end
  endtask

  // Mostly well-formed streams, the rest loose noise bytes
  task automatic fill_random(input int target);
    int made;
    int n;
    int k;
    int body_bytes;
    int groups;
    int bad_pct;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 80) begin
        groups  = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        bad_pct = ($urandom_range(99) < 85) ? 0 : 30;
        gen_stream(next_skip, next_start, groups, bad_pct, body_bytes);
        made += body_bytes;
      end else begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          push_raw(8'($urandom), (k == n - 1) && ($urandom_range(99) < 85));
        made += n;
      end
    end
  endtask

  // Block idle: every item accepted, every result in, pipeline flushed
  task automatic wait_drained();
    while (raw_stream.size() != 0 || in_valid || decoded_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic start_phase(input idle_mode_e mode, input int skip, input int sb);
    wait_drained();
    write_reg(REG_SKIP_BYTES, 16'(skip));
    // upper bits of the start bit write are don't care
    write_reg(REG_START_BIT, {13'($urandom), 3'(sb)});
    next_skip  = skip;
    next_start = sb;
    idle_mode  = mode;
  endtask

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: sender_rests = $urandom_range(99) < 45;
      IDLE_BOTH:   sender_rests = $urandom_range(99) < 14;
      default:     sender_rests = 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: receiver_stalls = $urandom_range(99) < 45;
      IDLE_BOTH:     receiver_stalls = $urandom_range(99) < 14;
      default:       receiver_stalls = 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents raw items from the queue
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    item_t next_item;
    if (rst_n && (!in_valid || in_taken)) begin
      if (raw_stream.size() != 0 && !sender_rests()) begin
        next_item = raw_stream.pop_front();
        in_valid      <= 1'b1;
        in_raw_byte   <= next_item.raw_byte;
        in_final_byte <= next_item.final_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_stalls();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: model update on accepted items, result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t fresh;
    result_t want;
    if (!rst_n) begin
      reset_model();
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready && decode_raw_byte(in_raw_byte, in_final_byte, fresh))
        decoded_bytes_due.push_back(fresh);
      if (out_valid && out_ready) begin
        if (decoded_bytes_due.size() == 0) begin
          $error("result item with none expected: data_byte %0h end_mark %0b",
                 out_data_byte, out_end_mark);
          mismatches++;
        end else begin
          want = decoded_bytes_due.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("has_byte", 8'(want.has_byte), 8'(out_has_byte));
          check_field("bad_code", 8'(want.bad_code), 8'(out_bad_code));
          check_field("end_mark", 8'(want.end_mark), 8'(out_end_mark));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gcr_bitstream_nibble_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int body_bytes;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all-ones gives invalid codes, all-zeros too, trailing
    // bits are dropped at the final byte
    push_raw(8'hFF, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'h00, 1'b1);
    // final byte alone: lone nibble dropped, empty result with end mark
    push_raw(8'h55, 1'b1);
    // clean stream of four groups
    gen_stream(0, 0, 4, 0, body_bytes);

    // skip count reloaded by a write in the middle of a stream
    push_raw(8'h52, 1'b0);
    wait_drained();
    write_reg(REG_SKIP_BYTES, 16'd1);
    push_raw(8'hAA, 1'b0);
    push_raw(8'h6B, 1'b1);

    // final byte that is itself skipped
    wait_drained();
    write_reg(REG_START_BIT, 16'hFFFB);
    push_raw(8'h0F, 1'b1);
    gen_stream(1, 3, 5, 20, body_bytes);

    // random phases over settings and idling patterns
    start_phase(IDLE_NONE, 0, 0);
    fill_random(PHASE_ITEMS);
    start_phase(IDLE_SENDER, 1, 7);
    fill_random(PHASE_ITEMS);
    start_phase(IDLE_RECEIVER, 3, 2);
    fill_random(PHASE_ITEMS);
    hold_req = !hold_req;
    start_phase(IDLE_BOTH, $urandom_range(0, 4), $urandom_range(0, 7));
    fill_random(PHASE_ITEMS);

    // skip count past one byte: one full stream behind it
    start_phase(IDLE_NONE, LONG_SKIP, 5);
    gen_stream(LONG_SKIP, 5, 20, 10, body_bytes);

    start_phase(IDLE_SENDER, $urandom_range(0, 4), $urandom_range(0, 7));
    fill_random(PHASE_ITEMS);
    start_phase(IDLE_RECEIVER, $urandom_range(0, 4), $urandom_range(0, 7));
    fill_random(PHASE_ITEMS);
    start_phase(IDLE_BOTH, $urandom_range(0, 4), $urandom_range(0, 7));
    fill_random(PHASE_ITEMS);

    wait_drained();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("gcr_bitstream_nibble_decoder verification clean");
    end else begin
      $display("gcr_bitstream_nibble_decoder verification failed");
    end
    $finish;
  end

endmodule
